// ----- src/iir_filterbank_analysis_defines.svh -----
// Assertion macros for the IIR filterbank analysis block.
// Used by the checker module; depends on clk and rst_n in the using scope.
`ifndef IIR_FILTERBANK_ANALYSIS_DEFINES_SVH
`define IIR_FILTERBANK_ANALYSIS_DEFINES_SVH

// Assertion sampled on clk, switched off while reset is low
`define IFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds during reset
`define IFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ifb_pkg.sv -----
// Shared constants and types of the IIR filterbank analysis block.
// No dependencies.
package ifb_pkg;
  localparam int MAX_CHANNELS = 32;
  localparam int MAX_SECTIONS = 8;
  localparam int MAX_DELAY    = 256;
  localparam int NCOEF        = 5;

  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int SEC_W  = $clog2(MAX_SECTIONS);
  localparam int DLY_W  = $clog2(MAX_DELAY);
  localparam int ROW_W  = CH_W + SEC_W;
  localparam int COEF_DEPTH = MAX_CHANNELS * MAX_SECTIONS * NCOEF;
  localparam int CLR_W  = CH_W + DLY_W;

  // Item kinds
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_COEF     = 2'd1;
  localparam logic [1:0] KIND_DELAY    = 2'd2;
  // no meaning: a transaction of this kind is dropped
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // Configuration register indexes
  localparam logic REG_NUM_CHANNELS = 1'b0;
  localparam logic REG_NUM_SECTIONS = 1'b1;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;
endpackage

// ----- src/ifb_if.sv -----
// Channel interfaces of the IIR filterbank analysis block.
// No dependencies.
interface ifb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [23:0] sample;
  logic [10:0]        index;
  logic signed [31:0] coef_value;
  logic [7:0]         delay_value;
  modport source (output valid, kind, sample, index, coef_value, delay_value, input ready);
  modport sink   (input valid, kind, sample, index, coef_value, delay_value, output ready);
endinterface

interface ifb_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         channel;
  logic signed [23:0] channel_sample;
  logic               last;
  modport source (output valid, channel, channel_sample, last, input ready);
  modport sink   (input valid, channel, channel_sample, last, output ready);
endinterface

interface ifb_cfg_if;
  logic       valid;
  logic       ready;
  logic       addr;
  logic [5:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/ifb_mac.sv -----
// Shared multiply-accumulate unit: one 32x24 product a cycle, 60-bit sum,
// rounding and saturation to Q1.23. Depends on ifb_pkg.
module ifb_mac (
  input  logic               clk,
  input  ifb_pkg::mac_ctrl_t ctrl,
  input  logic signed [31:0] coef,
  input  logic signed [23:0] data,
  output logic signed [23:0] y
);
  logic signed [55:0] prod_r;
  logic signed [59:0] acc_r;
  logic signed [59:0] rnd;
  logic signed [31:0] q;

  // product register, then accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * data;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + 60'(prod_r);
    end
  end

  // round half up, floor shift, saturate
  always_comb begin
    rnd = acc_r + 60'sd134217728;
    q   = 32'(rnd >>> 28);
    if (q > 32'sd8388607) begin
      y = 24'sd8388607;
    end else if (q < -32'sd8388608) begin
      y = -24'sd8388608;
    end else begin
      y = 24'(q);
    end
  end
endmodule

// ----- src/iir_filterbank_analysis.sv -----
// Top level of the IIR filterbank analysis block.
// Depends on ifb_pkg, ifb_if and ifb_mac.
//
// Each audio sample runs through every channel in use, each channel through
// num_sections DF-I biquads and then its own delay line; one result per
// channel, last channel flagged. One shared multiplier walks all sections:
// a section runs through a memory read, five products and the accumulate
// tail, and a write-back; a channel adds the delay memory step and the
// result register step, which waits out any output stall. The next item is
// taken only after the last channel's result, once the block is idle again.
// Coefficient and delay writes are taken in idle and leave it there.
// After reset a clearing pass over the MAX_CHANNELS*MAX_DELAY delay memory
// words zeroes the section history and delay memories; no item is accepted
// meanwhile.
module iir_filterbank_analysis (
  input  logic      clk,
  input  logic      rst_n,
  ifb_in_if.sink    in_ch,
  ifb_out_if.source out_ch,
  ifb_cfg_if.sink   cfg_ch
);
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_MAC   = 7'b0001000,
    ST_WB    = 7'b0010000,
    ST_DLY   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [5:0] num_ch_r;
  logic [3:0] num_sec_r;
  logic [5:0] nc_eff;
  logic [3:0] ns_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r  <= 6'd1;
      num_sec_r <= 4'd2;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        ifb_pkg::REG_NUM_CHANNELS: num_ch_r  <= cfg_ch.data;
        ifb_pkg::REG_NUM_SECTIONS: num_sec_r <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (num_ch_r == '0) begin
      nc_eff = 6'd1;
    end else if (num_ch_r > 6'(ifb_pkg::MAX_CHANNELS)) begin
      nc_eff = 6'(ifb_pkg::MAX_CHANNELS);
    end else begin
      nc_eff = num_ch_r;
    end
    if (num_sec_r == '0) begin
      ns_eff = 4'd1;
    end else if (num_sec_r > 4'(ifb_pkg::MAX_SECTIONS)) begin
      ns_eff = 4'(ifb_pkg::MAX_SECTIONS);
    end else begin
      ns_eff = num_sec_r;
    end
  end

  // sequencing registers
  logic [ifb_pkg::CLR_W-1:0] clr_cnt_r;
  logic [ifb_pkg::CH_W-1:0]  ch_r;
  logic [ifb_pkg::SEC_W-1:0] sec_r;
  logic [2:0]                step_r;
  logic signed [23:0]        v_r;
  logic                      in_acc;
  logic                      out_free;
  logic [ifb_pkg::ROW_W-1:0] row;
  logic                      last_sec;
  logic                      last_ch;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign row         = {ch_r, sec_r};
  assign last_sec    = ({1'b0, sec_r} == ns_eff - 4'd1);
  assign last_ch     = ({1'b0, ch_r} == nc_eff - 6'd1);

  // coefficient write address: index/5 by reciprocal, lane by subtraction
  logic [23:0]               recip;
  logic [ifb_pkg::ROW_W-1:0] cw_row;
  logic [2:0]                cw_lane;
  logic [10:0]               cw_base;
  assign recip   = 24'(in_ch.index) * 24'd6554;
  assign cw_row  = recip[15 +: ifb_pkg::ROW_W];
  assign cw_base = 11'(cw_row) * 11'd5;
  assign cw_lane = 3'(in_ch.index - cw_base);

  // coefficient memory: one row of five words per channel and section
  logic [ifb_pkg::NCOEF-1:0][31:0] coef_mem [1 << ifb_pkg::ROW_W];
  logic [ifb_pkg::NCOEF-1:0][31:0] coef_rd_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == ifb_pkg::KIND_COEF &&
        in_ch.index < 11'(ifb_pkg::COEF_DEPTH)) begin
      coef_mem[cw_row][cw_lane] <= in_ch.coef_value;
    end
    if (state_r == ST_READ) begin
      coef_rd_r <= coef_mem[row];
    end
  end

  // section history memory: row = {y2, y1, x2, x1}
  logic [3:0][23:0] hist_mem [1 << ifb_pkg::ROW_W];
  logic [3:0][23:0] hist_rd_r;
  logic             hist_we;
  logic [ifb_pkg::ROW_W-1:0] hist_wa;
  logic [3:0][23:0] hist_wd;
  logic signed [23:0] y;

  always_comb begin
    hist_we = 1'b0;
    hist_wa = row;
    hist_wd = {hist_rd_r[2], y, hist_rd_r[0], v_r};
    if (state_r == ST_CLEAR) begin
      hist_we = (clr_cnt_r < ifb_pkg::CLR_W'(1 << ifb_pkg::ROW_W));
      hist_wa = clr_cnt_r[ifb_pkg::ROW_W-1:0];
      hist_wd = '0;
    end else if (state_r == ST_WB) begin
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (state_r == ST_READ) begin
      hist_rd_r <= hist_mem[row];
    end
  end

  // per-channel delay and write pointer
  logic [ifb_pkg::DLY_W-1:0] chan_dly_r [ifb_pkg::MAX_CHANNELS];
  logic [ifb_pkg::DLY_W-1:0] wr_ptr_r   [ifb_pkg::MAX_CHANNELS];
  logic [ifb_pkg::DLY_W-1:0] d_cur, p_cur, rd_ptr, p_next;

  assign d_cur  = chan_dly_r[ch_r];
  assign p_cur  = wr_ptr_r[ch_r];
  assign rd_ptr = (p_cur >= d_cur) ? (p_cur - d_cur)
                : ifb_pkg::DLY_W'(32'(p_cur) + ifb_pkg::MAX_DELAY - 32'(d_cur));
  assign p_next = (32'(p_cur) + 1 >= ifb_pkg::MAX_DELAY) ? '0 : p_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ifb_pkg::MAX_CHANNELS; i++) begin
        chan_dly_r[i] <= '0;
        wr_ptr_r[i]   <= '0;
      end
    end else begin
      if (in_acc && in_ch.kind == ifb_pkg::KIND_DELAY &&
          in_ch.index < 11'(ifb_pkg::MAX_CHANNELS)) begin
        if (32'(in_ch.delay_value) >= ifb_pkg::MAX_DELAY) begin
          chan_dly_r[in_ch.index[ifb_pkg::CH_W-1:0]] <= ifb_pkg::DLY_W'(ifb_pkg::MAX_DELAY - 1);
        end else begin
          chan_dly_r[in_ch.index[ifb_pkg::CH_W-1:0]] <= ifb_pkg::DLY_W'(in_ch.delay_value);
        end
      end
      if (state_r == ST_DLY) begin
        wr_ptr_r[ch_r] <= p_next;
      end
    end
  end

  // delay ring memory; a zero delay bypasses it
  logic [23:0] dly_mem [1 << ifb_pkg::CLR_W];
  logic [23:0] dly_rd_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      dly_mem[clr_cnt_r] <= '0;
    end else if (state_r == ST_DLY) begin
      dly_mem[{ch_r, p_cur}] <= v_r;
    end
    if (state_r == ST_DLY) begin
      dly_rd_r <= dly_mem[{ch_r, rd_ptr}];
    end
  end

  // shared multiply-accumulate
  ifb_pkg::mac_ctrl_t mac_ctrl;
  logic signed [31:0] mac_coef;
  logic signed [23:0] mac_data;

  always_comb begin
    mac_ctrl.clr    = (state_r == ST_READ);
    mac_ctrl.mul_en = (state_r == ST_MAC) && (step_r < 3'd5);
    mac_ctrl.acc_en = (state_r == ST_MAC) && (step_r != 3'd0);
    mac_coef = coef_rd_r[0];
    mac_data = v_r;
    unique case (step_r)
      3'd1:    begin mac_coef = coef_rd_r[1]; mac_data = hist_rd_r[0]; end
      3'd2:    begin mac_coef = coef_rd_r[2]; mac_data = hist_rd_r[1]; end
      3'd3:    begin mac_coef = coef_rd_r[3]; mac_data = hist_rd_r[2]; end
      3'd4:    begin mac_coef = coef_rd_r[4]; mac_data = hist_rd_r[3]; end
      default: begin mac_coef = coef_rd_r[0]; mac_data = v_r; end
    endcase
  end

  ifb_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .coef (mac_coef),
    .data (mac_data),
    .y    (y)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc && in_ch.kind == ifb_pkg::KIND_SAMPLE) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MAC;
      ST_MAC:   if (step_r == 3'd5) state_nxt = ST_WB;
      ST_WB:    state_nxt = last_sec ? ST_DLY : ST_READ;
      ST_DLY:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = last_ch ? ST_IDLE : ST_READ;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      ch_r      <= '0;
      sec_r     <= '0;
      step_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_MAC) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (state_r == ST_IDLE) begin
        ch_r  <= '0;
        sec_r <= '0;
      end else if (state_r == ST_WB) begin
        sec_r <= last_sec ? '0 : sec_r + 1'b1;
      end else if (state_r == ST_OUT && out_free) begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  // the channel input is the original sample for every channel
  logic signed [23:0] in_sample_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_sample_r <= in_ch.sample;
    end
  end

  // running sample through the cascade
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r <= in_ch.sample;
    end else if (state_r == ST_WB) begin
      v_r <= y;
    end else if (state_r == ST_OUT && out_free) begin
      v_r <= in_sample_r;
    end
  end

  // result register
  logic                      out_valid_r;
  logic [4:0]                out_chan_r;
  logic signed [23:0]        out_smp_r;
  logic                      out_last_r;
  logic [ifb_pkg::DLY_W-1:0] d_hold_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DLY) begin
      d_hold_r <= d_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_chan_r <= 5'(ch_r);
      out_smp_r  <= (d_hold_r == '0) ? v_r : dly_rd_r;
      out_last_r <= last_ch;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel        = out_chan_r;
  assign out_ch.channel_sample = out_smp_r;
  assign out_ch.last           = out_last_r;
endmodule

// ----- src/ifb_checker.sv -----
// Port-level checker of the IIR filterbank analysis block, bound to the top.
// Depends on iir_filterbank_analysis_defines.svh.
`include "iir_filterbank_analysis_defines.svh"

module ifb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic cfg_ready
);
  // a result waiting for the sink stays offered
  `IFB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // no new item is taken while a non-final channel result is pending
  `IFB_ASSERT(a_busy, out_valid && !out_last |-> !in_ready, "input taken mid-sample")

  // nothing is offered in the cycle after reset
  `IFB_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid && !in_ready, "activity after reset")

  // configuration is always taken
  `IFB_ASSERT(a_cfg, cfg_ready, "configuration port stalled")
endmodule

bind iir_filterbank_analysis ifb_checker u_ifb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last),
  .cfg_ready (cfg_ch.ready)
);
